>>> rtl/core/rast_pkg.sv
// ----------------------------------------------------------------------------
// rast_pkg: shared types and codes for the range add / range sum tree
// Beat layouts of both channels and the action codes.
// ----------------------------------------------------------------------------
package rast_pkg;

  localparam int IDX_W = 18;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        last_index;
    logic signed [VAL_W-1:0] add_value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    range_error;
  } rsp_t;

endpackage

>>> rtl/core/rast_ram.sv
// ----------------------------------------------------------------------------
// rast_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rast_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/range_add_range_sum_tree_top.sv
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_top: segment tree with range add and range sum
// Node walk sequencer over one node RAM and one shared 32x18 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): one beat per action.
//   Add puts add_value on every position first_index..last_index, query
//   returns the wrapped 64-bit sum over that range, clear zeroes the store.
//   Response channel (rsp_valid / rsp_stall / rsp): one beat per request.
//   A bad range (first of zero, first above last, last beyond the count)
//   gives range_error and leaves the store alone.
//   cfg_we / cfg_wdata set the element count (0 reads as 1, above SIZE
//   saturates); write it only while idle.
// Node walk:
//   Each node on the walk passes through RAM read, two multiply partials,
//   accumulate and update, plus a stack pop after a fully covered node;
//   a node past the end of the array goes from the read straight to the pop.
//   A walk visits up to about four nodes per tree level, so a request's
//   time grows with the nodes it visits, set by the single node RAM port
//   and the shared multiplier. Error and unused actions skip the walk. One
//   request is in flight at a time.
// Reset and clear:
//   Reset and a clear action sweep all 2 * SIZE nodes of the RAM, one node a
//   cycle, with req_stall held high. A finished response holds in its
//   output register while rsp_stall is high; the next request may be taken.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_top #(
  parameter int SIZE = 131072
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  rast_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output rast_pkg::rsp_t                 rsp,
  input  logic                           cfg_we,
  input  logic [rast_pkg::IDX_W-1:0]     cfg_wdata
);

  import rast_pkg::*;

  localparam int NODES = 2 * SIZE;
  localparam int AW    = $clog2(NODES);
  localparam int NW    = $clog2(4 * SIZE + 2);
  localparam int SD    = $clog2(SIZE) + 3;
  localparam int SW    = $clog2(SD);
  localparam int PW    = $clog2(SD + 1);
  localparam int RESET_COUNT = (SIZE < 131072) ? SIZE : 131072;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_M0    = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_APPLY = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] slo;
    logic [IDX_W-1:0] shi;
    logic [NW-1:0]    node;
  } rec_t;

  logic [3:0]       state;
  logic [IDX_W-1:0] count;
  rec_t             cur;
  rec_t             stack [SD];
  logic [PW-1:0]    ptr;
  logic [PW-1:0]    ptr_m1;
  logic             is_add;
  logic [SUM_W-1:0] v64;
  logic [SUM_W-1:0] sum;
  logic             err;
  logic [49:0]      preg;
  logic [SUM_W-1:0] acc;
  logic [AW-1:0]    clr_addr;
  logic             is_reset_sweep;

  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] mid;
  logic             full;
  logic [31:0]      mul_a;
  logic [49:0]      prod;
  logic [127:0]     rdata;
  logic [SUM_W-1:0] rd_tot;
  logic [SUM_W-1:0] rd_pend;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [127:0]     ram_wdata;
  logic             req_bad;
  logic [IDX_W-1:0] cfg_clamped;
  logic [NW-1:0]    child_l;
  logic [NW-1:0]    child_r;

  assign req_stall = (state != S_IDLE);
  assign rd_tot    = rdata[127:64];
  assign rd_pend   = rdata[63:0];
  assign cnt       = cur.hi - cur.lo + IDX_W'(1);
  assign mid       = cur.slo + ((cur.shi - cur.slo) >> 1);
  assign full      = (cur.lo == cur.slo) && (cur.hi == cur.shi);
  assign child_l   = {cur.node[NW-2:0], 1'b0};
  assign child_r   = {cur.node[NW-2:0], 1'b1};
  assign ptr_m1    = ptr - PW'(1);
  assign req_bad   = (req.first_index == '0) || (req.first_index > req.last_index) ||
                     (req.last_index > count);

  // Multiply operand: add value for an add, the node's pending amount for a query.
  always_comb begin
    logic [SUM_W-1:0] a64;
    a64 = is_add ? v64 : rd_pend;
    mul_a = (state == S_M0) ? a64[31:0] : a64[63:32];
  end
  assign prod = mul_a * cnt;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = IDX_W'(1);
    end else if (32'(cfg_wdata) > SIZE) begin
      cfg_clamped = IDX_W'(SIZE);
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  // RAM write: sweep zeros while clearing, node update during an add.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur.node[AW-1:0];
    ram_wdata = {rd_tot + acc, rd_pend + (full ? v64 : '0)};
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_APPLY && is_add) begin
      ram_we = 1'b1;
    end
  end

  rast_ram #(
    .WIDTH(128),
    .DEPTH(NODES)
  ) u_nodes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cur.node[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= IDX_W'(RESET_COUNT);
    end else if (cfg_we) begin
      count <= cfg_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the response once the receiver takes it.
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            is_add   <= (req.action == ACT_ADD);
            v64      <= SUM_W'(req.add_value);
            sum      <= '0;
            err      <= 1'b0;
            ptr      <= '0;
            cur.lo   <= req.first_index;
            cur.hi   <= req.last_index;
            cur.slo  <= IDX_W'(1);
            cur.shi  <= count;
            cur.node <= NW'(1);
            case (req.action) inside
              ACT_ADD, ACT_QUERY: begin
                if (req_bad) begin
                  err   <= 1'b1;
                  state <= S_FIN;
                end else begin
                  state <= S_RD;
                end
              end
              ACT_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLR;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_RD: begin
          // Nodes past the end of the array are skipped.
          if (32'(cur.node) >= NODES) begin
            state <= S_NEXT;
          end else begin
            state <= S_M0;
          end
        end
        S_M0: begin
          preg  <= prod;
          state <= S_M1;
        end
        S_M1: begin
          acc   <= SUM_W'(preg);
          preg  <= prod;
          state <= S_M2;
        end
        S_M2: begin
          acc   <= acc + {preg[31:0], 32'b0};
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (!is_add) begin
            sum <= sum + (full ? rd_tot : acc);
          end
          if (full) begin
            state <= S_NEXT;
          end else begin
            state <= S_RD;
            if (cur.hi <= mid) begin
              cur.shi  <= mid;
              cur.node <= child_l;
            end else if (cur.lo >= mid + IDX_W'(1)) begin
              cur.slo  <= mid + IDX_W'(1);
              cur.node <= child_r;
            end else begin
              // Split: walk the left half now, hold the right half on the stack.
              stack[ptr[SW-1:0]] <= '{lo: mid + IDX_W'(1), hi: cur.hi,
                                      slo: mid + IDX_W'(1), shi: cur.shi,
                                      node: child_r};
              ptr      <= ptr + PW'(1);
              cur.hi   <= mid;
              cur.shi  <= mid;
              cur.node <= child_l;
            end
          end
        end
        S_NEXT: begin
          if (ptr == '0) begin
            state <= S_FIN;
          end else begin
            cur   <= stack[ptr_m1[SW-1:0]];
            ptr   <= ptr_m1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          // Hold until the output register is free.
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.range_sum   <= sum;
            rsp.range_error <= err;
            state           <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          // The sweep after reset delivers no response.
          if (clr_addr == AW'(NODES - 1)) begin
            state <= is_reset_sweep ? S_IDLE : S_FIN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_reset_sweep <= 1'b1;
    end else if (state == S_CLR && clr_addr == AW'(NODES - 1)) begin
      is_reset_sweep <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_err_zero_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.range_error |-> rsp.range_sum == '0)
    else $error("error response carries a nonzero sum");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    ptr <= PW'(SD))
    else $error("node stack overflow");
  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |-> ptr == '0 || state == S_IDLE)
    else $error("request taken during a walk");
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |=> req_stall || $past(clr_addr) == AW'(NODES - 1))
    else $error("request channel open during clearing sweep");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for range_add_range_sum_tree_top
// Drives add, query, clear and unused actions over several element counts,
// predicts each response beat with a segment tree of its own and compares
// the response beats in order, under random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  import rast_pkg::*;

  localparam int unsigned TREE_SIZE  = 131072;
  localparam int unsigned TREE_NODES = 2 * TREE_SIZE;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 12_000_000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_wdata;

  range_add_range_sum_tree_top #(.SIZE(TREE_SIZE)) DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow tree: node totals and pending adds, missing keys read as zero
  bit [63:0] node_sum [int unsigned];
  bit [63:0] node_pend [int unsigned];
  int unsigned span;          // element count as the block sees it

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Clock; reset is held high at the start of the test
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamp_span(input logic [IDX_W-1:0] v);
    if (v == 0) return 1;
    if (v > TREE_SIZE) return TREE_SIZE;
    return v;
  endfunction

  function automatic void tree_add(input int unsigned lo, input int unsigned hi,
                                   input int unsigned slo, input int unsigned shi,
                                   input int unsigned node, input bit [63:0] v);
    int unsigned mid;
    if (node >= TREE_NODES) return;
    node_sum[node] = node_sum[node] + v * 64'(hi - lo + 1);
    mid = slo + (shi - slo) / 2;
    if (lo == slo && hi == shi) begin
      node_pend[node] = node_pend[node] + v;
    end else if (hi <= mid) begin
      tree_add(lo, hi, slo, mid, 2 * node, v);
    end else if (lo >= mid + 1) begin
      tree_add(lo, hi, mid + 1, shi, 2 * node + 1, v);
    end else begin
      tree_add(lo, mid, slo, mid, 2 * node, v);
      tree_add(mid + 1, hi, mid + 1, shi, 2 * node + 1, v);
    end
  endfunction

  function automatic bit [63:0] tree_sum(input int unsigned lo, input int unsigned hi,
                                         input int unsigned slo, input int unsigned shi,
                                         input int unsigned node);
    int unsigned mid;
    bit [63:0] carried;
    if (node >= TREE_NODES) return 64'd0;
    if (lo == slo && hi == shi) return node_sum[node];
    carried = node_pend[node] * 64'(hi - lo + 1);
    mid = slo + (shi - slo) / 2;
    if (hi <= mid) return tree_sum(lo, hi, slo, mid, 2 * node) + carried;
    if (lo >= mid + 1) return tree_sum(lo, hi, mid + 1, shi, 2 * node + 1) + carried;
    return tree_sum(lo, mid, slo, mid, 2 * node)
         + tree_sum(mid + 1, hi, mid + 1, shi, 2 * node + 1) + carried;
  endfunction

  // Apply one request to the shadow tree and return the beat it must produce
  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    int unsigned lo;
    int unsigned hi;
    lo = r.first_index;
    hi = r.last_index;
    o.range_sum   = '0;
    o.range_error = 1'b0;
    if (r.action == ACT_ADD || r.action == ACT_QUERY) begin
      if (lo == 0 || lo > hi || hi > span) begin
        o.range_error = 1'b1;
      end else if (r.action == ACT_ADD) begin
        tree_add(lo, hi, 1, span, 1, {{32{r.add_value[31]}}, r.add_value});
      end else begin
        o.range_sum = tree_sum(lo, hi, 1, span, 1);
      end
    end else if (r.action == ACT_CLEAR) begin
      node_sum.delete();
      node_pend.delete();
    end
    return o;
  endfunction

  function automatic req_t make_req(input logic [1:0] act, input int unsigned lo,
                                    input int unsigned hi, input logic [31:0] v);
    req_t r;
    r.action      = act;
    r.first_index = lo[IDX_W-1:0];
    r.last_index  = hi[IDX_W-1:0];
    r.add_value   = v;
    return r;
  endfunction

  // Mostly well-formed adds and queries, a share of bad ranges and unused actions
  function automatic req_t random_req(input int unsigned cnt);
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] v;
    logic [1:0] act;
    pick = $urandom_range(99);
    act  = ($urandom_range(1) == 0) ? ACT_ADD : ACT_QUERY;
    v    = $urandom();
    if ($urandom_range(9) == 0) v = ($urandom_range(1) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
    else if ($urandom_range(3) == 0) v = $urandom_range(20) - 10;
    lo = $urandom_range(cnt, 1);
    if ($urandom_range(2) == 0) hi = (lo + $urandom_range(3) > cnt) ? cnt : lo + $urandom_range(3);
    else hi = $urandom_range(cnt, lo);
    if (pick < 2) begin
      act = ACT_UNUSED;
      lo  = $urandom_range(262143);
      hi  = $urandom_range(262143);
    end else if (pick < 5) begin
      lo = 0;                                   // first index of zero
    end else if (pick < 8) begin
      hi = cnt + 1 + $urandom_range(262142 - cnt);   // past the end
    end else if (pick < 11 && cnt > 1) begin
      lo = $urandom_range(cnt, 2);              // first above last
      hi = $urandom_range(lo - 1, 1);
    end else if (pick < 13) begin
      lo = $urandom_range(262143);              // raw noise in every bit
      hi = $urandom_range(262143);
    end
    return make_req(act, lo, hi, v);
  endfunction

  // Driver: advance to the next queued beat when the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else if (!req_valid || !req_stall) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_t r;
        r = pending_reqs.pop_front();
        expected_rsps.push_back(apply_request(r));
        req       <= r;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: compare each taken response beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response beat: sum %0d err %0b",
                                       rsp.range_sum, rsp.range_error);
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp.range_sum !== e.range_sum || rsp.range_error !== e.range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: sum exp %0d got %0d, err exp %0b got %0b",
                     e.range_sum, rsp.range_sum, e.range_error, rsp.range_error);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_count(input logic [IDX_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    span = clamp_span(v);
  endtask

  task automatic run_phase(input logic [IDX_W-1:0] cnt_word, input int unsigned n_items,
                           input int unsigned snd, input int unsigned rcv);
    write_count(cnt_word);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    repeat (n_items) pending_reqs.push_back(random_req(span));
    drain();
  endtask

  initial begin
    int unsigned top;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 19;
    recv_idle_pct = 46;
    span = TREE_SIZE;
    top = TREE_SIZE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset count: extremes, every action, bad ranges
    pending_reqs.push_back(make_req(ACT_ADD,   1, top, 32'h7fff_ffff));
    pending_reqs.push_back(make_req(ACT_ADD,   1, 1, 32'h8000_0000));
    pending_reqs.push_back(make_req(ACT_ADD,   top, top, 32'hffff_ffff));
    pending_reqs.push_back(make_req(ACT_ADD,   3, 65537, 32'h0001_2345));
    pending_reqs.push_back(make_req(ACT_QUERY, 1, top, 0));
    pending_reqs.push_back(make_req(ACT_QUERY, top, top, 0));
    pending_reqs.push_back(make_req(ACT_QUERY, 1, 1, 0));
    pending_reqs.push_back(make_req(ACT_QUERY, 2, 65536, 0));
    pending_reqs.push_back(make_req(ACT_ADD,   0, 5, 32'h1));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_ADD,   9, 8, 32'h1));
    pending_reqs.push_back(make_req(ACT_QUERY, 1, top + 1, 0));
    pending_reqs.push_back(make_req(ACT_ADD,   262143, 262143, 32'hffff_ffff));
    pending_reqs.push_back(make_req(ACT_UNUSED, 262143, 262143, 32'hffff_ffff));
    pending_reqs.push_back(make_req(ACT_QUERY, 1, top, 0));
    pending_reqs.push_back(make_req(ACT_CLEAR, 262143, 0, 32'hffff_ffff));
    pending_reqs.push_back(make_req(ACT_QUERY, 1, top, 0));
    pending_reqs.push_back(make_req(ACT_ADD,   100, 200, 32'h8000_0000));
    pending_reqs.push_back(make_req(ACT_QUERY, 150, 150, 0));
    pending_reqs.push_back(make_req(ACT_QUERY, 1, top, 0));
    drain();

    // Count changes keep the store: zero reads as one, overflow saturates
    run_phase(18'd0, 60, 19, 46);
    run_phase(18'd37, 300, 19, 46);
    run_phase(18'h3ffff, 100, 46, 19);
    run_phase(18'd5, 200, 46, 19);
    run_phase(18'd1000, 200, 0, 0);
    pending_reqs.push_back(make_req(ACT_CLEAR, 0, 262143, 32'h0));
    drain();
    run_phase(18'd64, 290, 0, 0);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
